>>> hw/rtl/ictu_pkg.sv
// shared constants, types and helpers for the inversion count segment tree unit
package ictu_pkg;

   localparam int LEVELS      = 10;
   localparam int MAX_VALUE   = 1024;
   localparam int LEAVES      = 1 << LEVELS;
   localparam int NODES       = 2 * LEAVES;
   localparam int NODE_W      = LEVELS + 1;
   localparam int CNT_W       = 11;
   localparam int VAL_W       = 11;
   localparam int STEP_W      = 4;
   localparam int WALK_END    = LEVELS + 1;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [VAL_W-1:0] LIMIT_RESET = VAL_W'(1024);
   localparam logic             REG_VALUE_LIMIT = 1'b0;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_RANK   = 1'b1;

   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [CNT_W-1:0] res;
      logic             borrow;
      logic             zero;
   } alu_out_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [VAL_W-1:0] position;
      logic             valid_res;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_status_type;

   function automatic logic [NODE_W-1:0] leaf_index(input logic [VAL_W-1:0] x);
      return NODE_W'(LEAVES - 1) + NODE_W'(x);
   endfunction

endpackage

>>> hw/rtl/inversion_count_segment_tree_unit.sv
// top level: request handshake, limit register, node memory and result register
// insert: one or two prefix walks when the range is not empty, then a mark pass when the value is valid
// rank: one node read and compare per tree level
// one request at a time, one node memory read per cycle; the next accept is possible while the result is shown,
// and a stalled full result register holds the sequencer until the response drains
// reset sets value_limit to 1024, empties the result, then clears all 2048 nodes
module inversion_count_segment_tree_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [ictu_pkg::VAL_W-1:0]           req_value,
   input  logic [ictu_pkg::VAL_W-1:0]           req_rank,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ictu_pkg::CNT_W-1:0]           rsp_count,
   output logic [ictu_pkg::VAL_W-1:0]           rsp_position,
   output logic                                 rsp_valid_res,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ictu_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ictu_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ictu_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   logic [ictu_pkg::VAL_W-1:0]  limit_ff, limit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ictu_pkg::result_type        rsp_data_ff, rsp_data_in;
   ictu_pkg::seq_status_type    seq_status;
   ictu_pkg::result_type        seq_result;
   logic                        out_free;
   logic                        start;
   logic                        csr_write;

   logic                        ram_wr_en;
   logic [ictu_pkg::NODE_W-1:0] ram_wr_addr;
   logic [ictu_pkg::CNT_W-1:0]  ram_wr_data;
   logic                        ram_rd_en;
   logic [ictu_pkg::NODE_W-1:0] ram_rd_addr;
   logic [ictu_pkg::CNT_W-1:0]  ram_rd_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[ictu_pkg::CSR_ADDR_W-1] == ictu_pkg::REG_VALUE_LIMIT);
   assign prdata    = (paddr[ictu_pkg::CSR_ADDR_W-1] == ictu_pkg::REG_VALUE_LIMIT)
                      ? ictu_pkg::CSR_DATA_W'(limit_ff) : '0;
   assign limit_in  = csr_write ? pwdata[ictu_pkg::VAL_W-1:0] : limit_ff;

   assign req_stall = !seq_status.idle;
   assign start     = req_valid && seq_status.idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   ictu_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_cmd     (req_cmd),
      .req_value   (req_value),
      .req_rank    (req_rank),
      .limit       (limit_ff),
      .out_free    (out_free),
      .status      (seq_status),
      .result      (seq_result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   ictu_ram #(
      .WIDTH (ictu_pkg::CNT_W),
      .DEPTH (ictu_pkg::NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ictu_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count     = rsp_data_ff.count;
   assign rsp_position  = rsp_data_ff.position;
   assign rsp_valid_res = rsp_data_ff.valid_res;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while sequencer stays idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_status.done |-> !(rsp_valid_ff && rsp_stall))
      else $error("result written over a stalled response");

   a_invalid_no_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_position == '0))
      else $error("invalid response carries a position");

   a_one_field: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_count != '0)) |-> (rsp_position == '0))
      else $error("count and position both set");

endmodule

>>> hw/rtl/ictu_ram.sv
// generic single write port, single read port ram with registered read
module ictu_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ictu_alu.sv
// shared add / subtract unit for node sums and rank descent
module ictu_alu (
   input  logic [ictu_pkg::CNT_W-1:0] a,
   input  logic [ictu_pkg::CNT_W-1:0] b,
   input  ictu_pkg::alu_op_type       op,
   output ictu_pkg::alu_out_type      result
);

   logic [ictu_pkg::CNT_W:0] wide;

   always_comb begin
      case (op)
         ictu_pkg::ALU_ADD: wide = {1'b0, a} + {1'b0, b};
         ictu_pkg::ALU_SUB: wide = {1'b0, a} - {1'b0, b};
         default:           wide = '0;
      endcase
      result.res    = wide[ictu_pkg::CNT_W-1:0];
      result.borrow = (op == ictu_pkg::ALU_SUB) && wide[ictu_pkg::CNT_W];
      result.zero   = (wide[ictu_pkg::CNT_W-1:0] == '0);
   end

endmodule

>>> hw/rtl/ictu_seq.sv
// sequencer that walks the node memory for count, mark and rank requests
module ictu_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              req_cmd,
   input  logic [ictu_pkg::VAL_W-1:0]        req_value,
   input  logic [ictu_pkg::VAL_W-1:0]        req_rank,
   input  logic [ictu_pkg::VAL_W-1:0]        limit,
   input  logic                              out_free,
   output ictu_pkg::seq_status_type          status,
   output ictu_pkg::result_type              result,
   output logic                              ram_wr_en,
   output logic [ictu_pkg::NODE_W-1:0]       ram_wr_addr,
   output logic [ictu_pkg::CNT_W-1:0]        ram_wr_data,
   output logic                              ram_rd_en,
   output logic [ictu_pkg::NODE_W-1:0]       ram_rd_addr,
   input  logic [ictu_pkg::CNT_W-1:0]        ram_rd_data
);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b0000000001,
      S_IDLE     = 10'b0000000010,
      S_PRE      = 10'b0000000100,
      S_MARK_RD  = 10'b0000001000,
      S_MARK_CHK = 10'b0000010000,
      S_UPD      = 10'b0000100000,
      S_RK_ROOT  = 10'b0001000000,
      S_RK_CHK   = 10'b0010000000,
      S_RK_DESC  = 10'b0100000000,
      S_DONE     = 10'b1000000000
   } state_type;

   localparam logic [ictu_pkg::VAL_W-1:0]  MAX_V    = ictu_pkg::VAL_W'(ictu_pkg::MAX_VALUE);
   localparam logic [ictu_pkg::STEP_W-1:0] STEP_END = ictu_pkg::STEP_W'(ictu_pkg::WALK_END);

   state_type                         state_ff, state_in;
   logic [ictu_pkg::NODE_W-1:0]       p_ff, p_in;
   logic [ictu_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                              walk_ff, walk_in;
   logic                              flag_ff, flag_in;
   logic [ictu_pkg::CNT_W-1:0]        acc_ff, acc_in;
   logic [ictu_pkg::VAL_W-1:0]        k_ff, k_in;
   logic [ictu_pkg::VAL_W-1:0]        lo_ff, lo_in;
   logic [ictu_pkg::VAL_W-1:0]        val_ff, val_in;
   logic                              cmd_ff, cmd_in;
   logic                              mark_ok_ff, mark_ok_in;
   logic                              ok_ff, ok_in;
   logic [ictu_pkg::VAL_W-1:0]        pos_ff, pos_in;

   logic [ictu_pkg::CNT_W-1:0]        alu_a, alu_b;
   ictu_pkg::alu_op_type              alu_op;
   ictu_pkg::alu_out_type             alu_out;

   logic [ictu_pkg::VAL_W-1:0]        lo_v, hi_v;
   logic                              go_left;
   logic [ictu_pkg::NODE_W-1:0]       np;

   ictu_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .op     (alu_op),
      .result (alu_out)
   );

   always_comb begin
      lo_v    = (req_value == '0) ? ictu_pkg::VAL_W'(1) : req_value;
      hi_v    = (limit > MAX_V) ? MAX_V : limit;
      go_left = alu_out.borrow || alu_out.zero;
      np      = {p_ff[ictu_pkg::NODE_W-2:0], ~go_left};
   end

   always_comb begin
      state_in    = state_ff;
      p_in        = p_ff;
      step_in     = step_ff;
      walk_in     = walk_ff;
      flag_in     = flag_ff;
      acc_in      = acc_ff;
      k_in        = k_ff;
      lo_in       = lo_ff;
      val_in      = val_ff;
      cmd_in      = cmd_ff;
      mark_ok_in  = mark_ok_ff;
      ok_in       = ok_ff;
      pos_in      = pos_ff;
      alu_a       = acc_ff;
      alu_b       = ram_rd_data;
      alu_op      = ictu_pkg::ALU_ADD;
      ram_wr_en   = 1'b0;
      ram_wr_addr = p_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = p_ff;

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
            p_in      = p_ff + ictu_pkg::NODE_W'(1);
            if (p_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in     = req_cmd;
               val_in     = req_value;
               k_in       = req_rank;
               lo_in      = lo_v - ictu_pkg::VAL_W'(1);
               acc_in     = '0;
               ok_in      = 1'b0;
               pos_in     = '0;
               mark_ok_in = (req_value != '0) && (req_value <= MAX_V);
               if (req_cmd == ictu_pkg::CMD_RANK) begin
                  state_in = S_RK_ROOT;
               end else if (lo_v <= hi_v) begin
                  p_in     = ictu_pkg::leaf_index(hi_v);
                  step_in  = '0;
                  walk_in  = 1'b0;
                  state_in = S_PRE;
               end else if ((req_value != '0) && (req_value <= MAX_V)) begin
                  state_in = S_MARK_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_PRE: begin
            alu_a  = acc_ff;
            alu_b  = ram_rd_data;
            alu_op = walk_ff ? ictu_pkg::ALU_SUB : ictu_pkg::ALU_ADD;
            if ((step_ff != '0) && flag_ff) begin
               acc_in = alu_out.res;
            end
            if (step_ff != STEP_END) begin
               ram_rd_en = 1'b1;
               step_in   = step_ff + ictu_pkg::STEP_W'(1);
               if (step_ff == '0) begin
                  ram_rd_addr = p_ff;
                  flag_in     = 1'b1;
               end else begin
                  ram_rd_addr = p_ff ^ ictu_pkg::NODE_W'(1);
                  flag_in     = p_ff[0];
                  p_in        = p_ff >> 1;
               end
            end else if (!walk_ff && (lo_ff != '0)) begin
               walk_in = 1'b1;
               p_in    = ictu_pkg::leaf_index(lo_ff);
               step_in = '0;
            end else if (mark_ok_ff) begin
               state_in = S_MARK_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MARK_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ictu_pkg::leaf_index(val_ff);
            p_in        = ictu_pkg::leaf_index(val_ff);
            state_in    = S_MARK_CHK;
         end
         S_MARK_CHK: begin
            if (ram_rd_data != '0) begin
               state_in = S_DONE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ictu_pkg::CNT_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = p_ff >> 1;
               p_in        = p_ff >> 1;
               state_in    = S_UPD;
            end
         end
         S_UPD: begin
            alu_a       = ram_rd_data;
            alu_b       = ictu_pkg::CNT_W'(1);
            alu_op      = ictu_pkg::ALU_ADD;
            ram_wr_en   = 1'b1;
            ram_wr_data = alu_out.res;
            if (p_ff == ictu_pkg::NODE_W'(1)) begin
               state_in = S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = p_ff >> 1;
               p_in        = p_ff >> 1;
            end
         end
         S_RK_ROOT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ictu_pkg::NODE_W'(1);
            state_in    = S_RK_CHK;
         end
         S_RK_CHK: begin
            alu_a  = k_ff;
            alu_b  = ram_rd_data;
            alu_op = ictu_pkg::ALU_SUB;
            if ((k_ff != '0) && go_left) begin
               p_in        = ictu_pkg::NODE_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = ictu_pkg::NODE_W'(2);
               state_in    = S_RK_DESC;
            end else begin
               ok_in    = 1'b0;
               pos_in   = '0;
               state_in = S_DONE;
            end
         end
         S_RK_DESC: begin
            alu_a  = k_ff;
            alu_b  = ram_rd_data;
            alu_op = ictu_pkg::ALU_SUB;
            if (!go_left) begin
               k_in = alu_out.res;
            end
            p_in = np;
            if (!np[ictu_pkg::NODE_W-1]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = {np[ictu_pkg::NODE_W-2:0], 1'b0};
            end else begin
               ok_in    = 1'b1;
               pos_in   = {1'b0, np[ictu_pkg::NODE_W-2:0]} + ictu_pkg::VAL_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         p_ff     <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      walk_ff    <= walk_in;
      flag_ff    <= flag_in;
      acc_ff     <= acc_in;
      k_ff       <= k_in;
      lo_ff      <= lo_in;
      val_ff     <= val_in;
      cmd_ff     <= cmd_in;
      mark_ok_ff <= mark_ok_in;
      ok_ff      <= ok_in;
      pos_ff     <= pos_in;
   end

   always_comb begin
      status.idle      = (state_ff == S_IDLE);
      status.done      = (state_ff == S_DONE) && out_free;
      result.count     = (cmd_ff == ictu_pkg::CMD_RANK) ? '0 : acc_ff;
      result.position  = (cmd_ff == ictu_pkg::CMD_RANK) ? pos_ff : '0;
      result.valid_res = (cmd_ff == ictu_pkg::CMD_RANK) ? ok_ff : mark_ok_ff;
   end

endmodule
